// ===== hw/rtl/csma_pkg.sv =====
// shared types and constants of the rts/cts medium access controller
// no dependencies

package csma_pkg;

   localparam int ADDR_W      = 48;
   localparam int TICK_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int RSPQ_DEPTH  = 4;
   localparam int RSPQ_PTR_W  = 2;
   localparam int RSPQ_CNT_W  = 3;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_REQ   = 2'd1;
   localparam logic [1:0] ACT_FRAME = 2'd2;

   localparam logic [1:0] FT_RTS  = 2'd0;
   localparam logic [1:0] FT_CTS  = 2'd1;
   localparam logic [1:0] FT_DATA = 2'd2;
   localparam logic [1:0] FT_ACK  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RCV_ADDR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_AP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIFS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BO     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_DUR     = 3'd6;

   typedef struct packed {
      logic [1:0]        action;
      logic [1:0]        frame_type;
      logic [ADDR_W-1:0] frame_src;
      logic [ADDR_W-1:0] frame_dest;
      logic [TICK_W-1:0] frame_res_duration;
      logic [TICK_W-1:0] backoff_draw;
   } req_type;

   typedef struct packed {
      logic [1:0]        tx_type;
      logic [ADDR_W-1:0] tx_src;
      logic [ADDR_W-1:0] tx_dest;
      logic [TICK_W-1:0] tx_res_duration;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src;
      logic [ADDR_W-1:0] dest;
   } pend_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd;
   } pq_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pq_stat_type;

endpackage

// ===== hw/rtl/csma_pend_queue.sv =====
// pending frame queue: circular buffer of source/destination pairs
// registered head read; uses csma_pkg

module csma_pend_queue #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  csma_pkg::pq_cmd_type     cmd,
   input  csma_pkg::pend_entry_type wdata,
   output csma_pkg::pq_stat_type    stat,
   output csma_pkg::pend_entry_type rdata
);
   import csma_pkg::*;

   localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pend_entry_type mem [DEPTH];
   pend_entry_type rdata_ff;
   logic [QW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [QW:0]    tail_sum;
   logic [QW-1:0]  tail;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign rdata      = rdata_ff;

   always_comb begin
      tail_sum = (QW+1)'(head_ff) + (QW+1)'(count_ff);
      if (tail_sum >= (QW+1)'(DEPTH)) begin
         tail = QW'(tail_sum - (QW+1)'(DEPTH));
      end else begin
         tail = tail_sum[QW-1:0];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
         if (head_ff == QW'(DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + QW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail] <= wdata;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[head_ff];
      end
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push into full pending queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.rd) |-> !stat.empty)
      else $error("pop or read of empty pending queue");

endmodule

// ===== hw/rtl/csma_rsp_fifo.sv =====
// result fifo: takes up to two beats per cycle, gives one beat per cycle while rsp_stall is low
// uses csma_pkg

module csma_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_n,
   input  csma_pkg::rsp_type             push_e0,
   input  csma_pkg::rsp_type             push_e1,
   output logic [csma_pkg::RSPQ_CNT_W-1:0] used,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output csma_pkg::rsp_type             rsp_data
);
   import csma_pkg::*;

   rsp_type               slot [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] used_ff, used_in;
   logic                  pop;

   assign rsp_valid = (used_ff != '0);
   assign rsp_data  = slot[rd_ptr_ff];
   assign used      = used_ff;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSPQ_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSPQ_PTR_W'(pop);
      used_in   = used_ff + RSPQ_CNT_W'(push_n) - RSPQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot[wr_ptr_ff] <= push_e0;
      end
      if (push_n == 2'd2) begin
         slot[wr_ptr_ff + RSPQ_PTR_W'(1)] <= push_e1;
      end
   end

endmodule

// ===== hw/rtl/csma_rts_cts_mac_controller.sv =====
// rts/cts medium access controller top level
// uses csma_pkg, csma_pend_queue, csma_rsp_fifo
//
// usage:
//   req channel (req_valid/req_stall/req_data) carries ticks, send requests and
//   received frames; rsp channel (rsp_valid/rsp_stall/rsp_data) carries the
//   frames to transmit, with last set on the final beat caused by one item.
//   csr port: csr_we writes csr_wdata to register csr_index (0 own address,
//   1 receiver address, 2 access point flag, 3 sifs, 4 difs, 5 max backoff,
//   6 transmit duration); write only while the block is idle.
// the first result beat of an item passes through the item register, then the result
//   fifo, before it is valid on the rsp port.
// throughput: one item per cycle while each item makes at most one beat and rsp_stall
//   is low; an item that makes two beats is given out one beat at a time on the
//   single-beat rsp port. the limit is the 4-entry result fifo: req_stall rises when it
//   and the item register could not take two more beats.
// reset: timers idle, collision count 0, partner address 0, queue empty,
//   registers at their defaults (sifs 1, difs 3, max backoff 6, duration 10).
// a stalled receiver fills the result fifo, then req_stall holds off input;
//   no beat is lost or repeated.

module csma_rts_cts_mac_controller #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  csma_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output csma_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [csma_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [csma_pkg::ADDR_W-1:0]   csr_wdata
);
   import csma_pkg::*;

   // configuration
   logic [ADDR_W-1:0] own_addr_ff;
   logic              is_ap_ff;
   logic [TICK_W-1:0] sifs_ff, difs_ff, max_bo_ff, tx_dur_ff;

   // protocol state
   logic              rw_act_ff, rw_act_in, bo_act_ff, bo_act_in, cw_act_ff, cw_act_in;
   logic [TICK_W-1:0] rw_cnt_ff, rw_cnt_in, bo_cnt_ff, bo_cnt_in, cw_cnt_ff, cw_cnt_in;
   logic [7:0]        crc_ff, crc_in;
   logic [ADDR_W-1:0] partner_ff, partner_in;

   // item register
   logic [1:0]        s1_n_ff, s1_n_in;
   logic              s1_sel_ff, s1_sel_in;
   rsp_type           s1_r0_ff, s1_r0_in, s1_r1_ff, s1_r1_in;

   logic                  req_accept;
   pq_cmd_type            pq_cmd;
   pq_stat_type           pq_stat;
   pend_entry_type        pq_wdata, pq_rdata;
   logic [RSPQ_CNT_W-1:0] rf_used;
   logic [RSPQ_CNT_W:0]   fill;
   rsp_type               e0;
   logic [31:0]           prod;
   logic [TICK_W-1:0]     bo_load;

   assign fill       = (RSPQ_CNT_W+1)'(rf_used) + (RSPQ_CNT_W+1)'(s1_n_ff);
   assign req_stall  = (fill > (RSPQ_CNT_W+1)'(RSPQ_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;

   assign pq_wdata.src  = req_data.frame_src;
   assign pq_wdata.dest = req_data.frame_dest;

   assign prod    = 32'(sifs_ff) * 32'(req_data.backoff_draw);
   assign bo_load = (prod > 32'(max_bo_ff)) ? max_bo_ff : prod[TICK_W-1:0];

   always_comb begin
      logic    bo_exp, rw_exp, cw_exp;
      rsp_type cts;
      bo_exp    = bo_act_ff && (bo_cnt_ff <= TICK_W'(1));
      rw_exp    = rw_act_ff && (rw_cnt_ff <= TICK_W'(1));
      cw_exp    = cw_act_ff && (cw_cnt_ff <= TICK_W'(1));
      cts       = '{tx_type: FT_CTS, tx_src: own_addr_ff, tx_dest: partner_ff,
                    tx_res_duration: tx_dur_ff, last: 1'b0};
      rw_act_in = rw_act_ff;
      rw_cnt_in = rw_cnt_ff;
      bo_act_in = bo_act_ff;
      bo_cnt_in = bo_cnt_ff;
      cw_act_in = cw_act_ff;
      cw_cnt_in = cw_cnt_ff;
      crc_in    = crc_ff;
      partner_in = partner_ff;
      s1_n_in   = 2'd0;
      s1_sel_in = 1'b0;
      s1_r0_in  = '0;
      s1_r1_in  = '0;
      pq_cmd    = '0;
      if (req_accept) begin
         unique case (req_data.action)
            ACT_TICK: begin
               if (bo_act_ff) begin
                  bo_act_in = !bo_exp;
                  bo_cnt_in = bo_exp ? '0 : bo_cnt_ff - TICK_W'(1);
               end
               if (rw_act_ff) begin
                  rw_act_in = !rw_exp;
                  rw_cnt_in = rw_exp ? '0 : rw_cnt_ff - TICK_W'(1);
               end
               if (cw_act_ff) begin
                  cw_act_in = !cw_exp;
                  cw_cnt_in = cw_exp ? '0 : cw_cnt_ff - TICK_W'(1);
               end
               if (bo_exp) begin
                  s1_r0_in = '{tx_type: FT_RTS, tx_src: own_addr_ff, tx_dest: partner_ff,
                               tx_res_duration: '0, last: 1'b0};
                  s1_n_in  = 2'd1;
                  if (!rw_act_in) begin
                     rw_act_in = 1'b1;
                     rw_cnt_in = difs_ff;
                  end
               end
               if (rw_exp && !bo_act_in) begin
                  bo_act_in = 1'b1;
                  bo_cnt_in = bo_load;
               end
               if (cw_exp) begin
                  if (crc_ff > 8'd1) begin
                     crc_in = '0;
                  end else if (s1_n_in == 2'd0) begin
                     s1_r0_in = cts;
                     s1_n_in  = 2'd1;
                  end else begin
                     s1_r1_in = cts;
                     s1_n_in  = 2'd2;
                  end
               end
            end
            ACT_REQ: begin
               if (!pq_stat.full) begin
                  pq_cmd.push = 1'b1;
                  rw_act_in   = 1'b1;
                  rw_cnt_in   = difs_ff;
                  s1_r0_in    = '{tx_type: FT_RTS, tx_src: req_data.frame_src,
                                  tx_dest: req_data.frame_dest,
                                  tx_res_duration: tx_dur_ff, last: 1'b0};
                  s1_n_in     = 2'd1;
               end
            end
            ACT_FRAME: begin
               if (req_data.frame_dest == own_addr_ff) begin
                  case (req_data.frame_type)
                     FT_RTS: begin
                        if (is_ap_ff) begin
                           if (!cw_act_ff) begin
                              cw_act_in  = 1'b1;
                              cw_cnt_in  = sifs_ff;
                              crc_in     = 8'd1;
                              partner_in = req_data.frame_src;
                           end else if (crc_ff != 8'hff) begin
                              crc_in = crc_ff + 8'd1;
                           end
                        end
                     end
                     FT_CTS: begin
                        rw_act_in = 1'b0;
                        rw_cnt_in = '0;
                        if (!pq_stat.empty) begin
                           pq_cmd.rd = 1'b1;
                           s1_sel_in = 1'b1;
                           s1_r0_in  = '{tx_type: FT_DATA, tx_src: '0, tx_dest: '0,
                                         tx_res_duration: tx_dur_ff, last: 1'b0};
                           s1_n_in   = 2'd1;
                        end
                     end
                     FT_DATA: begin
                        s1_r0_in = '{tx_type: FT_ACK, tx_src: req_data.frame_dest,
                                     tx_dest: req_data.frame_src,
                                     tx_res_duration: '0, last: 1'b0};
                        s1_n_in  = 2'd1;
                     end
                     default: begin
                        pq_cmd.pop = !pq_stat.empty;
                     end
                  endcase
               end else if (req_data.frame_type == FT_CTS) begin
                  rw_act_in = 1'b0;
                  rw_cnt_in = '0;
                  cw_act_in = 1'b0;
                  cw_cnt_in = '0;
                  bo_act_in = !pq_stat.empty;
                  bo_cnt_in = pq_stat.empty ? '0 : req_data.frame_res_duration;
               end
            end
            default: begin
            end
         endcase
      end
      if (s1_n_in == 2'd1) begin
         s1_r0_in.last = 1'b1;
      end
      if (s1_n_in == 2'd2) begin
         s1_r1_in.last = 1'b1;
      end
      if (csr_we && (csr_index == CSR_RCV_ADDR)) begin
         partner_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= '0;
         is_ap_ff    <= 1'b0;
         sifs_ff     <= TICK_W'(1);
         difs_ff     <= TICK_W'(3);
         max_bo_ff   <= TICK_W'(6);
         tx_dur_ff   <= TICK_W'(10);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDR: own_addr_ff <= csr_wdata;
            CSR_IS_AP:    is_ap_ff    <= csr_wdata[0];
            CSR_SIFS:     sifs_ff     <= csr_wdata[TICK_W-1:0];
            CSR_DIFS:     difs_ff     <= csr_wdata[TICK_W-1:0];
            CSR_MAX_BO:   max_bo_ff   <= csr_wdata[TICK_W-1:0];
            CSR_TX_DUR:   tx_dur_ff   <= csr_wdata[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rw_act_ff  <= 1'b0;
         rw_cnt_ff  <= '0;
         bo_act_ff  <= 1'b0;
         bo_cnt_ff  <= '0;
         cw_act_ff  <= 1'b0;
         cw_cnt_ff  <= '0;
         crc_ff     <= '0;
         partner_ff <= '0;
         s1_n_ff    <= '0;
         s1_sel_ff  <= 1'b0;
      end else begin
         rw_act_ff  <= rw_act_in;
         rw_cnt_ff  <= rw_cnt_in;
         bo_act_ff  <= bo_act_in;
         bo_cnt_ff  <= bo_cnt_in;
         cw_act_ff  <= cw_act_in;
         cw_cnt_ff  <= cw_cnt_in;
         crc_ff     <= crc_in;
         partner_ff <= partner_in;
         s1_n_ff    <= s1_n_in;
         s1_sel_ff  <= s1_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_r0_ff <= s1_r0_in;
      s1_r1_ff <= s1_r1_in;
   end

   // data frame takes its addresses from the queue head read
   always_comb begin
      e0 = s1_r0_ff;
      if (s1_sel_ff) begin
         e0.tx_src  = pq_rdata.src;
         e0.tx_dest = pq_rdata.dest;
      end
   end

   csma_pend_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_pend_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (pq_cmd),
      .wdata (pq_wdata),
      .stat  (pq_stat),
      .rdata (pq_rdata)
   );

   csma_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (s1_n_ff),
      .push_e0   (e0),
      .push_e1   (s1_r1_ff),
      .used      (rf_used),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      fill <= (RSPQ_CNT_W+1)'(RSPQ_DEPTH))
      else $error("result fifo overflow");

   a_data_alone: assert property (@(posedge clock) disable iff (reset)
      s1_sel_ff |-> (s1_n_ff == 2'd1))
      else $error("queued data beat not alone");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (rf_used == '0 && s1_n_ff == 2'd0) |-> !req_stall)
      else $error("stall while empty");

   a_sel_follows_read: assert property (@(posedge clock) disable iff (reset)
      pq_cmd.rd |=> s1_sel_ff)
      else $error("queue read without data beat");

endmodule

// ===== tb/sv/csma_rts_cts_mac_controller_tb.sv =====
// testbench for the rts/cts medium access controller: directed frame handling, queue overflow,
// rts saturation and randomized traffic under several register settings, checked beat by beat
// against an in-bench prediction of the transmitted frames; depends on csma_pkg and the rtl
`timescale 1ns / 1ps

module csma_rts_cts_mac_controller_tb;
   import csma_pkg::*;

   localparam int PEND_DEPTH = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int IDLE_CYCLES = 8;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] OWN_A = 48'h02AB_CDEF_1234;
   localparam logic [ADDR_W-1:0] RCV_A = 48'h0455_6677_8899;

   typedef enum int {TMR_BO = 0, TMR_RW = 1, TMR_CW = 2} timer_id_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [ADDR_W-1:0]     csr_wdata;

   // predicted controller state
   logic [ADDR_W-1:0] m_own, m_partner;
   logic              m_is_ap;
   logic [TICK_W-1:0] m_sifs, m_difs, m_max_bo, m_tx_dur;
   bit                tmr_on [3];
   logic [TICK_W-1:0] tmr_cnt [3];
   logic [7:0]        rts_seen;
   logic [ADDR_W-1:0] pend_src [PEND_DEPTH];
   logic [ADDR_W-1:0] pend_dest [PEND_DEPTH];
   int                pend_head, pend_cnt;

   rsp_type     tx_frames_due[$];
   rsp_type     want_beat;
   int          fail_count = 0;
   int          burst_left = 0;
   int unsigned cycle_count = 0;

   csma_rts_cts_mac_controller #(.QUEUE_DEPTH(PEND_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[csma_rts_cts_mac_controller] ERROR");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ADDR_W-1:0];
   endfunction

   function automatic req_type make_item(logic [1:0] act, logic [1:0] ft,
                                         logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dest,
                                         logic [TICK_W-1:0] dur, logic [TICK_W-1:0] draw);
      req_type it;
      it.action = act;
      it.frame_type = ft;
      it.frame_src = src;
      it.frame_dest = dest;
      it.frame_res_duration = dur;
      it.backoff_draw = draw;
      return it;
   endfunction

   function automatic void model_reset();
      m_own = '0;
      m_partner = '0;
      m_is_ap = 1'b0;
      m_sifs = 16'd1;
      m_difs = 16'd3;
      m_max_bo = 16'd6;
      m_tx_dur = 16'd10;
      for (int i = 0; i < 3; i++) begin
         tmr_on[i] = 1'b0;
         tmr_cnt[i] = '0;
      end
      rts_seen = '0;
      pend_head = 0;
      pend_cnt = 0;
   endfunction

   function automatic void load_timer(timer_id_type t, logic [TICK_W-1:0] val);
      tmr_on[t] = 1'b1;
      tmr_cnt[t] = val;
   endfunction

   function automatic void stop_timer(timer_id_type t);
      tmr_on[t] = 1'b0;
      tmr_cnt[t] = '0;
   endfunction

   // count one tick, true on expiry
   function automatic bit timer_fires(timer_id_type t);
      if (!tmr_on[t])
         return 1'b0;
      if (tmr_cnt[t] <= 1) begin
         stop_timer(t);
         return 1'b1;
      end
      tmr_cnt[t] = tmr_cnt[t] - 1'b1;
      return 1'b0;
   endfunction

   function automatic void queue_tx(logic [1:0] ft, logic [ADDR_W-1:0] src,
                                    logic [ADDR_W-1:0] dest, logic [TICK_W-1:0] dur);
      rsp_type b;
      b.tx_type = ft;
      b.tx_src = src;
      b.tx_dest = dest;
      b.tx_res_duration = dur;
      b.last = 1'b0;
      tx_frames_due = {tx_frames_due, b};
   endfunction

   function automatic void predict_tx_frames(req_type it);
      int due_before;
      bit bo_fire, rw_fire, cw_fire;
      logic [31:0] prod;
      int slot;
      due_before = tx_frames_due.size();
      case (it.action)
         ACT_TICK: begin
            bo_fire = timer_fires(TMR_BO);
            rw_fire = timer_fires(TMR_RW);
            cw_fire = timer_fires(TMR_CW);
            if (bo_fire) begin
               queue_tx(FT_RTS, m_own, m_partner, '0);
               if (!tmr_on[TMR_RW])
                  load_timer(TMR_RW, m_difs);
            end
            if (rw_fire && !tmr_on[TMR_BO]) begin
               prod = 32'(m_sifs) * 32'(it.backoff_draw);
               if (prod > {16'd0, m_max_bo})
                  prod = {16'd0, m_max_bo};
               load_timer(TMR_BO, prod[TICK_W-1:0]);
            end
            if (cw_fire) begin
               if (rts_seen > 1)
                  rts_seen = '0;
               else
                  queue_tx(FT_CTS, m_own, m_partner, m_tx_dur);
            end
         end
         ACT_REQ: begin
            if (pend_cnt < PEND_DEPTH) begin
               slot = (pend_head + pend_cnt) % PEND_DEPTH;
               pend_src[slot] = it.frame_src;
               pend_dest[slot] = it.frame_dest;
               pend_cnt++;
               load_timer(TMR_RW, m_difs);
               queue_tx(FT_RTS, it.frame_src, it.frame_dest, m_tx_dur);
            end
         end
         ACT_FRAME: begin
            if (it.frame_dest == m_own) begin
               case (it.frame_type)
                  FT_RTS: begin
                     if (m_is_ap) begin
                        if (!tmr_on[TMR_CW]) begin
                           load_timer(TMR_CW, m_sifs);
                           rts_seen = 8'd1;
                           m_partner = it.frame_src;
                        end else if (rts_seen != 8'hFF) begin
                           rts_seen = rts_seen + 1'b1;
                        end
                     end
                  end
                  FT_CTS: begin
                     stop_timer(TMR_RW);
                     if (pend_cnt > 0)
                        queue_tx(FT_DATA, pend_src[pend_head], pend_dest[pend_head], m_tx_dur);
                  end
                  FT_DATA: queue_tx(FT_ACK, it.frame_dest, it.frame_src, '0);
                  default: begin
                     if (pend_cnt > 0) begin
                        pend_head = (pend_head + 1) % PEND_DEPTH;
                        pend_cnt--;
                     end
                  end
               endcase
            end else if (it.frame_type == FT_CTS) begin
               stop_timer(TMR_RW);
               stop_timer(TMR_CW);
               stop_timer(TMR_BO);
               if (pend_cnt > 0)
                  load_timer(TMR_BO, it.frame_res_duration);
            end
         end
         default: ;
      endcase
      if (tx_frames_due.size() > due_before)
         tx_frames_due[tx_frames_due.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string fname, logic [ADDR_W-1:0] want,
                                       logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", fname, want, got);
         fail_count++;
      end
   endfunction

   // rsp beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (tx_frames_due.size() == 0) begin
            $error("unexpected beat: type %0d src %0h dest %0h dur %0h last %0b",
                   rsp_data.tx_type, rsp_data.tx_src, rsp_data.tx_dest,
                   rsp_data.tx_res_duration, rsp_data.last);
            fail_count++;
         end else begin
            want_beat = tx_frames_due[0];
            tx_frames_due.delete(0);
            check_field("tx_type", want_beat.tx_type, rsp_data.tx_type);
            check_field("tx_src", want_beat.tx_src, rsp_data.tx_src);
            check_field("tx_dest", want_beat.tx_dest, rsp_data.tx_dest);
            check_field("tx_res_duration", want_beat.tx_res_duration, rsp_data.tx_res_duration);
            check_field("last", want_beat.last, rsp_data.last);
         end
      end
   end

   // receiver stall pattern
   initial begin
      stall_mode_type stall_mode;
      int mode_left;
      stall_mode = STALL_NONE;
      mode_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (cycle_count % 3 != 0);
         endcase
      end
   end

   task automatic send_item(req_type it);
      int gap;
      req_valid <= 1'b1;
      req_data <= it;
      do
         @(posedge clock);
      while (req_stall);
      predict_tx_frames(it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tx_frames_due.size() != 0)
         @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_OWN_ADDR: m_own = val;
         CSR_RCV_ADDR: m_partner = val;
         CSR_IS_AP:  m_is_ap = val[0];
         CSR_SIFS:   m_sifs = val[TICK_W-1:0];
         CSR_DIFS:   m_difs = val[TICK_W-1:0];
         CSR_MAX_BO: m_max_bo = val[TICK_W-1:0];
         CSR_TX_DUR: m_tx_dur = val[TICK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_profile(logic [ADDR_W-1:0] own, logic [ADDR_W-1:0] rcv, logic ap,
                                logic [TICK_W-1:0] sifs, logic [TICK_W-1:0] difs,
                                logic [TICK_W-1:0] max_bo, logic [TICK_W-1:0] dur);
      wait_idle();
      write_reg(CSR_OWN_ADDR, own);
      write_reg(CSR_RCV_ADDR, rcv);
      write_reg(CSR_IS_AP, {47'd0, ap});
      write_reg(CSR_SIFS, {32'd0, sifs});
      write_reg(CSR_DIFS, {32'd0, difs});
      write_reg(CSR_MAX_BO, {32'd0, max_bo});
      write_reg(CSR_TX_DUR, {32'd0, dur});
      csr_we <= 1'b0;
   endtask

   task automatic test_frame_handling();
      apply_profile(OWN_A, RCV_A, 1'b1, 16'd1, 16'd2, 16'd6, 16'd10);
      send_item(make_item(ACT_UNUSED, FT_ACK, '1, '1, '1, '1));
      send_item(make_item(ACT_REQ, FT_RTS, '1, '0, '0, '0));
      // foreign cts with zero duration, backoff expires on next tick
      send_item(make_item(ACT_FRAME, FT_CTS, 48'h1111, '0, '0, '0));
      send_item(make_item(ACT_FRAME, FT_RTS, 48'h0777_0000_0001, OWN_A, '0, '0));
      // backoff and collision window expire together
      send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, '1));
      send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, '1));
      send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, '1));
      send_item(make_item(ACT_FRAME, FT_CTS, RCV_A, OWN_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_DATA, 48'h0123_4567_89AB, OWN_A, '1, '0));
      send_item(make_item(ACT_FRAME, FT_ACK, RCV_A, OWN_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_ACK, RCV_A, OWN_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_CTS, RCV_A, OWN_A, '0, '0));
      // several rts in one window means a collision
      send_item(make_item(ACT_FRAME, FT_RTS, 48'h0A, OWN_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_RTS, 48'h0B, OWN_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_RTS, 48'h0C, OWN_A, '0, '0));
      send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, '0));
      send_item(make_item(ACT_FRAME, FT_RTS, 48'h0D, RCV_A, '0, '0));
      send_item(make_item(ACT_FRAME, FT_DATA, 48'h0E, RCV_A, '0, '0));
      send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, '0));
   endtask

   task automatic test_queue_overflow();
      for (int i = 0; i < PEND_DEPTH + 1; i++)
         send_item(make_item(ACT_REQ, FT_RTS, rand48(), rand48(), '0, '0));
      send_item(make_item(ACT_FRAME, FT_CTS, OWN_A, ~OWN_A, '1, '0));
      send_item(make_item(ACT_FRAME, FT_CTS, RCV_A, OWN_A, '0, '0));
      for (int i = 0; i < PEND_DEPTH + 1; i++)
         send_item(make_item(ACT_FRAME, FT_ACK, RCV_A, OWN_A, '0, '0));
   endtask

   task automatic test_rts_saturation();
      apply_profile(rand48(), rand48(), 1'b1, 16'd3, 16'd5, 16'd4, 16'd7);
      for (int i = 0; i < 300; i++)
         send_item(make_item(ACT_FRAME, FT_RTS, rand48(), m_own, '0, '0));
      repeat (4) send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, 16'd1));
      send_item(make_item(ACT_FRAME, FT_RTS, rand48(), m_own, '0, '0));
      repeat (4) send_item(make_item(ACT_TICK, FT_RTS, '0, '0, '0, 16'd1));
   endtask

   function automatic req_type random_traffic_item(output bit noise);
      int pick;
      logic [ADDR_W-1:0] other;
      logic [TICK_W-1:0] draw;
      pick = $urandom_range(0, 99);
      noise = 1'b0;
      draw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      other = rand48();
      if (other == m_own)
         other = ~other;
      if (pick < 35)
         return make_item(ACT_TICK, 2'($urandom), rand48(), rand48(), 16'($urandom), draw);
      if (pick < 47)
         return make_item(ACT_REQ, 2'($urandom), rand48(), rand48(), 16'($urandom), draw);
      if (pick < 82)
         return make_item(ACT_FRAME, 2'($urandom), rand48(), m_own, 16'($urandom), draw);
      if (pick < 87)
         return make_item(ACT_FRAME, FT_CTS, rand48(), other,
                          ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 8)), draw);
      noise = 1'b1;
      return make_item(2'($urandom), 2'($urandom), rand48(), rand48(), 16'($urandom),
                       16'($urandom));
   endfunction

   task automatic test_random_traffic();
      int counted;
      bit noise;
      req_type it;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_profile(rand48(), rand48(), 1'b1, 16'd1, 16'd3, 16'd6, 16'd10);
            1: apply_profile('0, '1, 1'b0, '0, '0, '0, '0);
            2: apply_profile('1, '0, 1'b1, '1, '1, '1, '1);
            default: apply_profile(rand48(), rand48(), 1'($urandom), 16'($urandom_range(0, 4)),
                                   16'($urandom_range(0, 8)), 16'($urandom_range(0, 24)),
                                   16'($urandom));
         endcase
         counted = 0;
         while (counted < 120) begin
            it = random_traffic_item(noise);
            send_item(it);
            if (!noise)
               counted++;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_frame_handling();
      test_queue_overflow();
      test_rts_saturation();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0)
         $display("[csma_rts_cts_mac_controller] OK");
      else
         $display("[csma_rts_cts_mac_controller] ERROR");
      $finish;
   end

endmodule
